[hw/rtl/min_coin_change_unit_macros.svh]
// assertion macros used by the min_coin_change_unit rtl
`ifndef MIN_COIN_CHANGE_UNIT_MACROS_SVH
`define MIN_COIN_CHANGE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define MCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MCC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define MCC_ASSERT(lbl, prop, msg)
`define MCC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[hw/rtl/mcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg
// Types, constants and the control store of the coin change sequencer.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int unsigned AMT_W   = 10;
  localparam int unsigned COIN_W  = 10;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned ENTRY_W = 11;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned CMP_W   = 17;

  localparam logic [ENTRY_W-1:0] UNREACHED = '1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

  // sequencer step addresses
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_INIT  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_COIN  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    COND_IN_XFER,
    COND_TRIVIAL,
    COND_LAST_COIN,
    COND_LAST_AMT,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    cond_e             cond;
    logic [STEP_W-1:0] pc_true;
    logic [STEP_W-1:0] pc_false;
    logic              take;   // input channel open
    logic              init;   // start a new table fill
    logic              issue;  // try one coin
    logic              drain;  // close one amount
    logic              emit;   // load the output register
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{cond: COND_IN_XFER, pc_true: STEP_INIT, pc_false: STEP_IDLE,
          take: 1'b1, init: 1'b0, issue: 1'b0, drain: 1'b0, emit: 1'b0};
    unique case (step)
      STEP_IDLE: ;
      STEP_INIT: begin
        c = '{cond: COND_TRIVIAL, pc_true: STEP_EMIT, pc_false: STEP_COIN,
              take: 1'b0, init: 1'b1, issue: 1'b0, drain: 1'b0, emit: 1'b0};
      end
      STEP_COIN: begin
        c = '{cond: COND_LAST_COIN, pc_true: STEP_DRAIN, pc_false: STEP_COIN,
              take: 1'b0, init: 1'b0, issue: 1'b1, drain: 1'b0, emit: 1'b0};
      end
      STEP_DRAIN: begin
        c = '{cond: COND_LAST_AMT, pc_true: STEP_EMIT, pc_false: STEP_COIN,
              take: 1'b0, init: 1'b0, issue: 1'b0, drain: 1'b1, emit: 1'b0};
      end
      STEP_EMIT: begin
        c = '{cond: COND_OUT_FREE, pc_true: STEP_IDLE, pc_false: STEP_EMIT,
              take: 1'b0, init: 1'b0, issue: 1'b0, drain: 1'b0, emit: 1'b1};
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/mcc_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_table
// Scratch table of fewest-coin counts: one write port, one registered read.
// ----------------------------------------------------------------------------
module mcc_table #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [mcc_pkg::ENTRY_W-1:0]      wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [mcc_pkg::ENTRY_W-1:0]      rdata_o
);

  logic [mcc_pkg::ENTRY_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/min_coin_change_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_coin_change_unit
// Fewest coins for a target amount, by a table fill run from a control store.
// ----------------------------------------------------------------------------
//  channel  valid       stall        payload
//  in       in_valid_i  in_stall_o   target_amount_i
//  out      out_valid_o out_stall_i  coin_total_o, reachable_o
//  cfg      cfg_we_i    -            cfg_index_i, cfg_data_i
//
// each amount from 1 to target tries every coin in use, one table read per
// coin step, then is closed in a drain step. target zero or beyond the table
// goes from init straight to emit. a new target is taken only in the idle step.
// reset clears the sequencer and sets coin_count and every coin value to 1;
// the table is never cleared, every entry is written before it is read.
// a finished result sits in the output register; the sequencer waits in its
// emit step only while that register is still full and stalled.
`include "min_coin_change_unit_macros.svh"

module min_coin_change_unit #(
  parameter int unsigned MAX_AMOUNT = 1024,
  parameter int unsigned MAX_COINS  = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcc_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [mcc_pkg::COIN_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcc_pkg::AMT_W-1:0]     target_amount_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mcc_pkg::AMT_W-1:0]     coin_total_o,
  output logic                          reachable_o
);

  localparam int unsigned AW = $clog2(MAX_AMOUNT);

  // configuration
  logic [mcc_pkg::CNT_W-1:0]  coin_count_q;
  logic [mcc_pkg::COIN_W-1:0] coin_value_q [MAX_COINS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_count_q <= mcc_pkg::CNT_W'(1);
      for (int k = 0; k < MAX_COINS; k++) begin
        coin_value_q[k] <= mcc_pkg::COIN_W'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == mcc_pkg::REG_COIN_COUNT) begin
        coin_count_q <= cfg_data_i[mcc_pkg::CNT_W-1:0];
      end
      for (int k = 0; k < MAX_COINS; k++) begin
        if (cfg_index_i == mcc_pkg::IDX_W'(mcc_pkg::REG_COIN_VALUE_0 + k)) begin
          coin_value_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // sequencer
  logic [mcc_pkg::STEP_W-1:0]  pc_q, pc_d;
  mcc_pkg::ctrl_t              ctrl;
  logic                        cond_true;

  logic [mcc_pkg::AMT_W-1:0]   target_q;
  logic [mcc_pkg::AMT_W-1:0]   amt_q;
  logic [mcc_pkg::CNT_W-1:0]   coin_q;
  logic [mcc_pkg::ENTRY_W-1:0] best_q, best_new;
  logic [mcc_pkg::ENTRY_W-1:0] res_q;
  logic                        pend_q;

  logic                        out_valid_q;
  logic [mcc_pkg::AMT_W-1:0]   coin_total_q;
  logic                        reachable_q;

  logic [mcc_pkg::CNT_W-1:0]   used;
  logic [mcc_pkg::COIN_W-1:0]  cur_value;
  logic                        usable, last_coin, last_amt, too_big, trivial, out_free;
  logic                        in_xfer;
  logic [mcc_pkg::AMT_W-1:0]   rd_amt;
  logic [mcc_pkg::ENTRY_W-1:0] rd_data;
  logic [mcc_pkg::ENTRY_W-1:0] cand;
  logic                        tbl_we;
  logic [mcc_pkg::ENTRY_W-1:0] tbl_wdata;
  logic [mcc_pkg::AMT_W-1:0]   tbl_wamt;

  assign ctrl    = mcc_pkg::ucode(pc_q);
  assign in_xfer = in_valid_i && ctrl.take;

  assign used = (coin_count_q > mcc_pkg::CNT_W'(MAX_COINS)) ? mcc_pkg::CNT_W'(MAX_COINS)
                                                            : coin_count_q;

  always_comb begin
    cur_value = '0;
    for (int k = 0; k < MAX_COINS; k++) begin
      if (coin_q == mcc_pkg::CNT_W'(k)) begin
        cur_value = coin_value_q[k];
      end
    end
  end

  assign usable    = (coin_q < used) && (cur_value != '0) && (cur_value <= amt_q);
  assign last_coin = ({1'b0, coin_q} + 4'd1) >= {1'b0, used};
  assign last_amt  = (amt_q == target_q);
  assign too_big   = mcc_pkg::CMP_W'(target_q) >= mcc_pkg::CMP_W'(MAX_AMOUNT);
  assign trivial   = (target_q == '0) || too_big;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_amt    = amt_q - cur_value;

  // fold the read that came back into the running minimum
  assign cand     = mcc_pkg::ENTRY_W'(rd_data + 1'b1);
  assign best_new = (pend_q && (rd_data != mcc_pkg::UNREACHED) && (cand < best_q)) ? cand
                                                                                   : best_q;

  always_comb begin
    unique case (ctrl.cond)
      mcc_pkg::COND_IN_XFER:   cond_true = in_valid_i;
      mcc_pkg::COND_TRIVIAL:   cond_true = trivial;
      mcc_pkg::COND_LAST_COIN: cond_true = last_coin;
      mcc_pkg::COND_LAST_AMT:  cond_true = last_amt;
      mcc_pkg::COND_OUT_FREE:  cond_true = out_free;
      default:                 cond_true = 1'b0;
    endcase
    pc_d = cond_true ? ctrl.pc_true : ctrl.pc_false;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= mcc_pkg::STEP_IDLE;
      pend_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (ctrl.init || ctrl.drain) begin
        pend_q <= 1'b0;
      end else if (ctrl.issue) begin
        pend_q <= usable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      target_q <= target_amount_i;
    end
    if (ctrl.init) begin
      amt_q  <= mcc_pkg::AMT_W'(1);
      coin_q <= '0;
      best_q <= mcc_pkg::UNREACHED;
      res_q  <= '0;
    end else if (ctrl.issue) begin
      coin_q <= coin_q + 1'b1;
      best_q <= best_new;
    end else if (ctrl.drain) begin
      amt_q  <= amt_q + 1'b1;
      coin_q <= '0;
      best_q <= mcc_pkg::UNREACHED;
      res_q  <= best_new;
    end
  end

  // entry zero at start, then one entry per amount
  assign tbl_we    = ctrl.init || ctrl.drain;
  assign tbl_wamt  = ctrl.init ? '0 : amt_q;
  assign tbl_wdata = ctrl.init ? '0 : best_new;

  mcc_table #(
    .DEPTH (MAX_AMOUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(tbl_wamt)),
    .wdata_i (tbl_wdata),
    .raddr_i (AW'(rd_amt)),
    .rdata_o (rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && out_free) begin
      reachable_q  <= !too_big && (res_q != mcc_pkg::UNREACHED);
      coin_total_q <= (!too_big && (res_q != mcc_pkg::UNREACHED))
                      ? res_q[mcc_pkg::AMT_W-1:0] : '0;
    end
  end

  assign in_stall_o   = !ctrl.take;
  assign out_valid_o  = out_valid_q;
  assign coin_total_o = coin_total_q;
  assign reachable_o  = reachable_q;

  `MCC_ASSERT(a_unreach_zero, !(out_valid_o && !reachable_o) || (coin_total_o == '0), "unreachable result with nonzero count")
  `MCC_ASSERT(a_amt_in_range, (pc_q != mcc_pkg::STEP_COIN) || ((amt_q != '0) && (amt_q <= target_q)), "amount outside fill range")
  `MCC_ASSERT_NEXT(a_xfer_starts, in_valid_i && !in_stall_o, pc_q == mcc_pkg::STEP_INIT, "transfer did not start a fill")

endmodule
